/* rtl/vpl_pkg.sv */
package vpl_pkg;

    // Fixed datapath widths
    localparam int W_FLT = 40;   // filtered speed
    localparam int W_ACC = 64;   // working accumulator and divider dividend
    localparam int W_M   = 48;   // 200*filtered + integral, multiplicand
    localparam int W_MLO = 24;   // low slice of the multiplicand
    localparam int W_KP  = 16;
    localparam int W_OUT = 16;
    localparam int PC_W  = 5;

    localparam int INTEGRAL_LIMIT = 10000;
    localparam int DRIVE_MAX      = 32767;
    localparam int DRIVE_MIN_MAG  = 32768;

    // Program labels
    localparam logic [PC_W-1:0] ST_LOAD  = 5'd0;
    localparam logic [PC_W-1:0] ST_DIV1  = 5'd2;
    localparam logic [PC_W-1:0] ST_DIV2  = 5'd7;
    localparam logic [PC_W-1:0] ST_DIV3  = 5'd15;
    localparam logic [PC_W-1:0] ST_DRIVE = 5'd16;
    localparam logic [PC_W-1:0] ST_LAST  = 5'd16;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_SUM,
        OP_MIX1,
        OP_MIX2,
        OP_FILT,
        OP_INTEG,
        OP_MSCALE,
        OP_MADD,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DRIVE
    } t_op;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_INPUT,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } t_cond;

    typedef enum logic [1:0] {
        DSEL_5,
        DSEL_10,
        DSEL_25
    } t_dsel;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        t_dsel           dsel;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic logic [4:0] dsel_value(input t_dsel d);
        case (d)
            DSEL_5:  return 5'd5;
            DSEL_10: return 5'd10;
            DSEL_25: return 5'd25;
            default: return 5'd25;
        endcase
    endfunction

    function automatic t_uword mk(input t_op op, input t_cond c, input t_dsel d,
                                  input logic [PC_W-1:0] tgt);
        t_uword w;
        w.op     = op;
        w.cond   = c;
        w.dsel   = d;
        w.target = tgt;
        return w;
    endfunction

    // Control store: one word per step
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        case (pc)
            5'd0:    return mk(OP_LOAD,      COND_NO_INPUT, DSEL_5,  ST_LOAD);
            5'd1:    return mk(OP_DIV_START, COND_NONE,     DSEL_5,  ST_LOAD);
            5'd2:    return mk(OP_DIV_STEP,  COND_DIV_BUSY, DSEL_5,  ST_DIV1);
            5'd3:    return mk(OP_SUM,       COND_NONE,     DSEL_5,  ST_LOAD);
            5'd4:    return mk(OP_MIX1,      COND_NONE,     DSEL_5,  ST_LOAD);
            5'd5:    return mk(OP_MIX2,      COND_NONE,     DSEL_5,  ST_LOAD);
            5'd6:    return mk(OP_DIV_START, COND_NONE,     DSEL_10, ST_LOAD);
            5'd7:    return mk(OP_DIV_STEP,  COND_DIV_BUSY, DSEL_10, ST_DIV2);
            5'd8:    return mk(OP_FILT,      COND_NONE,     DSEL_10, ST_LOAD);
            5'd9:    return mk(OP_INTEG,     COND_NONE,     DSEL_10, ST_LOAD);
            5'd10:   return mk(OP_MSCALE,    COND_NONE,     DSEL_10, ST_LOAD);
            5'd11:   return mk(OP_MADD,      COND_NONE,     DSEL_10, ST_LOAD);
            5'd12:   return mk(OP_MUL_LO,    COND_NONE,     DSEL_25, ST_LOAD);
            5'd13:   return mk(OP_MUL_HI,    COND_NONE,     DSEL_25, ST_LOAD);
            5'd14:   return mk(OP_DIV_START, COND_NONE,     DSEL_25, ST_LOAD);
            5'd15:   return mk(OP_DIV_STEP,  COND_DIV_BUSY, DSEL_25, ST_DIV3);
            5'd16:   return mk(OP_DRIVE,     COND_OUT_BUSY, DSEL_25, ST_DRIVE);
            default: return mk(OP_NOP,       COND_NONE,     DSEL_5,  ST_LOAD);
        endcase
    endfunction

endpackage

/* rtl/velocity_pi_loop.sv */
// Velocity PI loop, one control tick per input word, run by a 17-step microprogram.
// Three divisions by a small constant each run one byte of a 64-bit dividend per cycle.
// The next input is taken once the previous word's steps are done, while a result waits.
// Reset (synchronous, active low) clears the filter, integrator, gain and sequencer.
module velocity_pi_loop #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vpl_pkg::W_KP-1:0]    i_cfg_wdata,   // proportional_gain, Q8.8
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [11:0] left_wheel_speed, [23:12] right_wheel_speed, [39:24] target_speed
    input  logic [39:0]                 s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [15:0] drive_value
    output logic [vpl_pkg::W_OUT-1:0]   m_axis_tdata
);
    import vpl_pkg::*;

    localparam int W_INT     = FRACTION_BITS + 16;
    localparam int W_IS      = ((W_INT > W_FLT) ? W_INT : W_FLT) + 1;
    localparam int TGT_SHIFT = FRACTION_BITS - 3;
    localparam int DRV_SHIFT = FRACTION_BITS + 11;
    localparam int W_PLO     = W_MLO + 1 + W_KP;
    localparam int W_PHI     = W_M - W_MLO + W_KP;
    localparam logic signed [W_IS-1:0] INT_MAX = W_IS'(INTEGRAL_LIMIT) <<< FRACTION_BITS;
    localparam logic signed [W_IS-1:0] INT_MIN = -INT_MAX;

    // Sequencer
    logic [PC_W-1:0]          r_pc, n_pc;
    t_uword                   w_uw;
    logic                     w_jump;
    logic                     w_out_busy;

    // Datapath registers
    logic signed [W_KP-1:0]   r_kp;
    logic signed [W_FLT-1:0]  r_flt;
    logic signed [W_INT-1:0]  r_int;
    logic signed [W_FLT-1:0]  r_sum;
    logic signed [12:0]       r_lr;
    logic signed [W_ACC-1:0]  r_a;
    logic signed [W_PLO-1:0]  r_p;
    logic [W_ACC-1:0]         r_dmag;
    logic                     r_dneg;
    logic [4:0]               r_rem;
    logic [2:0]               r_cnt;
    logic [W_OUT-1:0]         r_out;
    logic                     r_ovalid;

    // Combinational helpers
    logic [4:0]               w_div;
    logic [4:0]               w_rem;
    logic [7:0]               w_qbyte;
    logic signed [W_ACC-1:0]  w_q_s;
    logic signed [W_IS-1:0]   w_is;
    logic signed [W_IS-1:0]   w_is_cl;
    logic signed [W_PLO-1:0]  w_plo;
    logic signed [W_PHI-1:0]  w_phi;
    logic [W_ACC-1:0]         w_sh;
    logic [W_OUT-1:0]         w_drive;

    // Fetch control word and pick next step
    always_comb begin
        w_uw       = ucode(r_pc);
        w_out_busy = r_ovalid && !m_axis_tready;
        case (w_uw.cond)
            COND_NONE:     w_jump = 1'b0;
            COND_NO_INPUT: w_jump = !s_axis_tvalid;
            COND_DIV_BUSY: w_jump = (r_cnt != 3'd7);
            COND_OUT_BUSY: w_jump = w_out_busy;
            default:       w_jump = 1'b0;
        endcase
        if (w_jump) begin
            n_pc = w_uw.target;
        end else if (r_pc == ST_LAST) begin
            n_pc = ST_LOAD;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    assign s_axis_tready = (w_uw.op == OP_LOAD);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    // Divide one byte of the dividend by a small constant, MSB first
    always_comb begin
        logic [5:0] t;
        logic [7:0] dbyte;
        w_div  = dsel_value(w_uw.dsel);
        dbyte  = r_dmag[W_ACC-1 -: 8];
        w_rem  = r_rem;
        w_qbyte = '0;
        for (int i = 7; i >= 0; i--) begin
            t = {w_rem, dbyte[i]};
            if (t >= {1'b0, w_div}) begin
                t = t - {1'b0, w_div};
                w_qbyte[i] = 1'b1;
            end
            w_rem = t[4:0];
        end
    end

    assign w_q_s = r_dneg ? -$signed(r_dmag) : $signed(r_dmag);

    // Integrator add and clamp
    always_comb begin
        w_is = W_IS'(r_int) + W_IS'(r_flt);
        if (w_is > INT_MAX) begin
            w_is_cl = INT_MAX;
        end else if (w_is < INT_MIN) begin
            w_is_cl = INT_MIN;
        end else begin
            w_is_cl = w_is;
        end
    end

    // Split multiply of 200*filtered + integral by kp
    assign w_plo = $signed({1'b0, r_a[W_MLO-1:0]}) * r_kp;
    assign w_phi = $signed(r_a[W_M-1:W_MLO]) * r_kp;

    // Scale down, truncate toward zero, saturate
    always_comb begin
        w_sh = r_dmag >> DRV_SHIFT;
        if (r_dneg) begin
            if (w_sh > W_ACC'(DRIVE_MIN_MAG)) begin
                w_drive = W_OUT'(DRIVE_MIN_MAG);
            end else begin
                w_drive = W_OUT'(-w_sh);
            end
        end else begin
            if (w_sh > W_ACC'(DRIVE_MAX)) begin
                w_drive = W_OUT'(DRIVE_MAX);
            end else begin
                w_drive = W_OUT'(w_sh);
            end
        end
    end

    // Sequencer state, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= ST_LOAD;
            r_ovalid <= 1'b0;
            r_kp     <= '0;
            r_flt    <= '0;
            r_int    <= '0;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_we) begin
                r_kp <= i_cfg_wdata;
            end

            // Raise valid on a new drive word, drop it once taken
            if (w_uw.op == OP_DRIVE && !w_out_busy) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (w_uw.op)
                OP_LOAD: begin
                    if (s_axis_tvalid) begin
                        r_lr <= 13'($signed(s_axis_tdata[11:0]))
                              + 13'($signed(s_axis_tdata[23:12]));
                        r_a  <= W_ACC'($signed(s_axis_tdata[39:24])) <<< TGT_SHIFT;
                    end
                end
                OP_DIV_START: begin
                    r_dneg <= r_a[W_ACC-1];
                    r_dmag <= r_a[W_ACC-1] ? W_ACC'(-r_a) : W_ACC'(r_a);
                    r_rem  <= '0;
                    r_cnt  <= '0;
                end
                OP_DIV_STEP: begin
                    r_dmag <= {r_dmag[W_ACC-9:0], w_qbyte};
                    r_rem  <= w_rem;
                    r_cnt  <= r_cnt + 1'b1;
                end
                OP_SUM: begin
                    r_sum <= (W_FLT'(r_lr) <<< FRACTION_BITS) + w_q_s[W_FLT-1:0];
                end
                OP_MIX1: begin
                    r_a <= (W_ACC'(r_flt) <<< 3) - W_ACC'(r_flt);
                end
                OP_MIX2: begin
                    r_a <= r_a + (W_ACC'(r_sum) <<< 1) + W_ACC'(r_sum);
                end
                OP_FILT: begin
                    r_flt <= w_q_s[W_FLT-1:0];
                end
                OP_INTEG: begin
                    r_int <= w_is_cl[W_INT-1:0];
                end
                OP_MSCALE: begin
                    r_a <= (W_ACC'(r_flt) <<< 7) + (W_ACC'(r_flt) <<< 6)
                         + (W_ACC'(r_flt) <<< 3);
                end
                OP_MADD: begin
                    r_a <= r_a + W_ACC'(r_int);
                end
                OP_MUL_LO: begin
                    r_p <= w_plo;
                end
                OP_MUL_HI: begin
                    r_a <= (W_ACC'(w_phi) <<< W_MLO) + W_ACC'(r_p);
                end
                OP_DRIVE: begin
                    // Hold until the previous word has left
                    if (!w_out_busy) begin
                        r_out <= w_drive;
                    end
                end
                OP_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int FRACTION_BITS      = 16;
    localparam int GAIN_FRACTION_BITS = 8;
    localparam int TARGET_DIVISOR     = 40;
    localparam int INTEGRAL_DIVISOR   = 200;
    localparam int RESULT_LATENCY     = 48;
    localparam int SEGMENT_WORDS      = 50;
    localparam int SEGMENTS           = 5;
    localparam int LONG_HOLD_CYCLES   = 400;
    localparam int N_DIRECTED         = 22;

    typedef struct packed {
        bit                 load_gain;
        logic signed [15:0] gain;
        logic signed [11:0] left;
        logic signed [11:0] right;
        logic signed [15:0] target;
        bit                 known;
        logic signed [15:0] drive;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    // Loop state as seen by the predictor
    longint             filter_state;
    longint             integral_state;
    logic signed [15:0] loop_gain;

    logic signed [15:0] drive_expect_q[$];
    int                 fail_count = 0;
    int                 src_idle_pct = 6;
    int                 snk_idle_pct = 57;
    int                 hold_left = 0;

    t_stim_row directed_rows [0:N_DIRECTED-1] = '{
        // gain still at reset: no drive whatever the speeds
        '{1'b0, 16'sd0, 12'sd2047, 12'sd2047, 16'sd32767, 1'b1, 16'sd0},
        '{1'b0, 16'sd0, 12'sh800, 12'sh800, 16'sh8000, 1'b1, 16'sd0},
        '{1'b0, 16'sd0, 12'sd0, 12'sd0, 16'sd0, 1'b1, 16'sd0},
        // full positive gain, full forward speed: drive pegs high
        '{1'b1, 16'sd32767, 12'sd2047, 12'sd2047, 16'sd32767, 1'b0, 16'sd0},
        '{1'b0, 16'sd0, 12'sd2047, 12'sd2047, 16'sd32767, 1'b0, 16'sd0},
        '{1'b0, 16'sd0, 12'sd2047, 12'sd2047, 16'sd32767, 1'b1, 16'sd32767},
        // full negative gain: drive pegs low
        '{1'b1, 16'sh8000, 12'sd2047, 12'sd2047, 16'sd32767, 1'b1, 16'sh8000},
        // unit gain: integrator held at its upper clamp, then pulled back down
        '{1'b1, 16'sd256, 12'sd2047, 12'sd2047, 16'sd32767, 1'b0, 16'sd0},
        '{1'b0, 16'sd0, 12'sd2047, 12'sd2047, 16'sd32767, 1'b0, 16'sd0},
        '{1'b0, 16'sd0, 12'sd2047, 12'sd2047, 16'sd32767, 1'b0, 16'sd0},
        '{1'b0, 16'sd0, 12'sh800, 12'sh800, 16'sh8000, 1'b0, 16'sd0},
        '{1'b0, 16'sd0, 12'sh800, 12'sh800, 16'sh8000, 1'b0, 16'sd0},
        '{1'b0, 16'sd0, 12'sh800, 12'sh800, 16'sh8000, 1'b0, 16'sd0},
        '{1'b0, 16'sd0, 12'sh800, 12'sh800, 16'sh8000, 1'b0, 16'sd0},
        // smallest gain, target just around the divide-by-40 boundary
        '{1'b1, 16'sd1, 12'sd0, 12'sd0, 16'sd39, 1'b0, 16'sd0},
        '{1'b0, 16'sd0, 12'sd0, 12'sd0, -16'sd39, 1'b0, 16'sd0},
        '{1'b0, 16'sd0, 12'sd0, 12'sd0, 16'sd40, 1'b0, 16'sd0},
        '{1'b0, 16'sd0, 12'sd0, 12'sd0, -16'sd41, 1'b0, 16'sd0},
        // wheels in opposite directions, then half gain with both wheels slow forward
        '{1'b1, -16'sd1, 12'sd2047, 12'sh800, 16'sd0, 1'b0, 16'sd0},
        '{1'b0, 16'sd0, 12'sh800, 12'sd2047, -16'sd1, 1'b0, 16'sd0},
        '{1'b1, 16'sd0, 12'sd5, -12'sd7, 16'sd1234, 1'b1, 16'sd0},
        '{1'b1, 16'sd128, 12'sd1, 12'sd1, 16'sd0, 1'b0, 16'sd0}
    };

    velocity_pi_loop dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // One control tick: filter the speed sum, integrate, form the drive
    function automatic logic signed [15:0] advance_velocity_loop(
        input logic signed [11:0] left,
        input logic signed [11:0] right,
        input logic signed [15:0] target
    );
        longint unity;
        longint clamp;
        longint speed_sum;
        longint numer;
        longint denom;
        longint drive;
        unity = longint'(1) << FRACTION_BITS;
        clamp = longint'(vpl_pkg::INTEGRAL_LIMIT) * unity;
        speed_sum = (longint'(left) + longint'(right)) * unity
                  + (longint'(target) * unity) / TARGET_DIVISOR;
        filter_state = (7 * filter_state + 3 * speed_sum) / 10;
        integral_state = integral_state + filter_state;
        if (integral_state > clamp) begin
            integral_state = clamp;
        end
        if (integral_state < -clamp) begin
            integral_state = -clamp;
        end
        numer = longint'(INTEGRAL_DIVISOR) * filter_state * longint'(loop_gain)
              + integral_state * longint'(loop_gain);
        denom = longint'(INTEGRAL_DIVISOR)
              * (longint'(1) << (FRACTION_BITS + GAIN_FRACTION_BITS));
        drive = numer / denom;
        if (drive > vpl_pkg::DRIVE_MAX) begin
            drive = vpl_pkg::DRIVE_MAX;
        end
        if (drive < -longint'(vpl_pkg::DRIVE_MIN_MAG)) begin
            drive = -longint'(vpl_pkg::DRIVE_MIN_MAG);
        end
        return drive[15:0];
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endtask

    // Offer one word; called just after a falling edge, returns just after one
    task automatic offer_word(
        input logic signed [11:0] left,
        input logic signed [11:0] right,
        input logic signed [15:0] target,
        input bit                 known,
        input logic signed [15:0] known_drive
    );
        logic signed [15:0] predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {target, right, left};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        predicted = advance_velocity_loop(left, right, target);
        drive_expect_q.push_back(known ? known_drive : predicted);
        @(negedge i_clk);
    endtask

    // Drop valid, let every result drain, then let the sequencer settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (drive_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (RESULT_LATENCY) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_gain(input logic signed [15:0] gain);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= gain;
        loop_gain = gain;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'sd32767;
            1:       return 16'sh8000;
            2:       return 16'sd0;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 1023)) - 16'sd512;
        endcase
    endfunction

    // Mostly random speeds, with runs at the rails to reach both clamps
    task automatic offer_random_word();
        logic signed [11:0] left;
        logic signed [11:0] right;
        logic signed [15:0] target;
        left   = 12'($urandom);
        right  = 12'($urandom);
        target = 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1: begin
                left   = 12'sd2047 - 12'($urandom_range(0, 3));
                right  = 12'sd2047;
                target = 16'sd32767;
            end
            2, 3: begin
                left   = 12'sh800 + 12'($urandom_range(0, 3));
                right  = 12'sh800;
                target = 16'sh8000;
            end
            4: begin
                left  = 12'($urandom_range(0, 15)) - 12'sd8;
                right = 12'($urandom_range(0, 15)) - 12'sd8;
            end
            default: ;
        endcase
        offer_word(left, right, target, 1'b0, 16'sd0);
    endtask

    // Receiver: random backpressure plus one long hold
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // Check each drive word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (drive_expect_q.size() == 0) begin
                note_failure($sformatf("unexpected drive word %0d",
                                       $signed(m_axis_tdata)));
            end else begin
                if (m_axis_tdata !== drive_expect_q[0]) begin
                    note_failure($sformatf("drive_value expected %0d got %0d",
                                           drive_expect_q[0], $signed(m_axis_tdata)));
                end
                void'(drive_expect_q.pop_front());
            end
        end
    end

    initial begin
        #10_000_000;
        $display("velocity_pi_loop verification failed");
        $finish;
    end

    initial begin
        filter_state   = 0;
        integral_state = 0;
        loop_gain      = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table
        for (int row = 0; row < N_DIRECTED; row++) begin
            if (directed_rows[row].load_gain) begin
                load_gain(directed_rows[row].gain);
            end
            offer_word(directed_rows[row].left, directed_rows[row].right,
                       directed_rows[row].target, directed_rows[row].known,
                       directed_rows[row].drive);
        end

        // Random phases: sender idles lightly, then receiver, then neither
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 57 : 0;
            snk_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 6 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                load_gain(pick_gain());
                if (phase == 0 && seg == 1) begin
                    hold_left = LONG_HOLD_CYCLES;
                end
                for (int n = 0; n < SEGMENT_WORDS; n++) begin
                    offer_random_word();
                end
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("velocity_pi_loop verification clean");
        end else begin
            $display("velocity_pi_loop verification failed");
        end
        $finish;
    end

endmodule
